### rtl/modbus_rtu_slave_engine_assert.svh
// assertion macros for the modbus rtu slave engine checker
// no dependencies; included by the checker file
`ifndef MODBUS_RTU_SLAVE_ENGINE_ASSERT_SVH
`define MODBUS_RTU_SLAVE_ENGINE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define MRS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mrs assertion failed");

// next-cycle implication, disabled in reset
`define MRS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mrs assertion failed");

`endif

### rtl/mrs_pkg.sv
// shared types, constants and crc function for the modbus rtu slave engine
// no dependencies
package mrs_pkg;

   localparam int BANK_DEPTH_DEF  = 128;
   localparam int FRAME_BYTES_DEF = 256;
   localparam int MAX_READ_DEF    = 29;
   localparam int FRAME_LEN_W     = 9;
   localparam int QUEUE_DEPTH     = 2;
   localparam int MW_DATA_START   = 7;
   localparam int MIN_FRAME       = 8;
   localparam int HDR_BYTES       = 6;

   localparam logic [7:0]  FC_READ_COILS    = 8'h01;
   localparam logic [7:0]  FC_READ_DISCRETE = 8'h02;
   localparam logic [7:0]  FC_READ_HOLDING  = 8'h03;
   localparam logic [7:0]  FC_READ_INPUT    = 8'h04;
   localparam logic [7:0]  FC_WRITE_COIL    = 8'h05;
   localparam logic [7:0]  FC_WRITE_REG     = 8'h06;
   localparam logic [7:0]  FC_WRITE_COILS   = 8'h0F;
   localparam logic [7:0]  FC_WRITE_REGS    = 8'h10;

   localparam logic        ACT_BYTE = 1'b0;
   localparam logic        ACT_LOAD = 1'b1;

   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'hA001;
   localparam logic [15:0] DISC_ON     = 16'hFF00;
   localparam logic [15:0] DISC_OFF    = 16'h0000;
   localparam logic [15:0] GAP_RESET   = 16'd1000;
   localparam logic [7:0]  ADDR_RESET  = 8'd1;
   localparam logic [15:0] REG_BAUD    = 16'd1;
   localparam logic [15:0] REG_GAP     = 16'd2;
   localparam logic [15:0] BAUD_MIN    = 16'd1;
   localparam logic [15:0] BAUD_MAX    = 16'd4;

   typedef struct packed {
      logic       action;
      logic [7:0] data_byte;
      logic       frame_end;
      logic [7:0] input_bits;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  tx_byte;
      logic        last_byte;
      logic [7:0]  coil_image;
      logic [2:0]  baud_select;
      logic [15:0] gap_interval;
   } rsp_item_type;

   typedef struct packed {
      logic                   is_load;
      logic [7:0]             bits;
      logic [FRAME_LEN_W-1:0] n;
      logic [7:0]             fc;
      logic [15:0]            addr;
      logic [15:0]            len;
   } job_type;

   typedef struct packed {
      logic clearing;
      logic frame_done;
   } back_status_type;

   function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

### rtl/mrs_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module mrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### rtl/mrs_front.sv
// front end: takes items, stores frame bytes, tracks crc and header, queues jobs
// depends on mrs_pkg
module mrs_front #(
   parameter int FRAME_BYTES = mrs_pkg::FRAME_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  mrs_pkg::req_item_type         req_item,
   input  logic [7:0]                    dev_addr,
   input  mrs_pkg::back_status_type      status,
   input  logic                          q_full,
   output logic                          q_push,
   output mrs_pkg::job_type              q_data,
   output logic                          fr_wr_en,
   output logic [$clog2(FRAME_BYTES)-1:0] fr_wr_addr,
   output logic [7:0]                    fr_wr_data
);
   import mrs_pkg::*;

   localparam int FW = $clog2(FRAME_BYTES);

   logic [FRAME_LEN_W-1:0] len_ff, len_in;
   logic                   ovf_ff, ovf_in;
   logic [15:0]            crc_cur_ff, crc_cur_in;
   logic [15:0]            crc_p1_ff, crc_p1_in;
   logic [7:0]             last_ff, last_in;
   logic [7:0]             hdr_ff [HDR_BYTES];
   logic                   pend_ff, pend_in;
   logic                   accept, room, frame_ok;
   logic [FRAME_LEN_W-1:0] n_val;

   assign req_stall = status.clearing | q_full | pend_ff;
   assign accept    = req_valid & ~req_stall;
   assign room      = len_ff < FRAME_LEN_W'(FRAME_BYTES);
   assign n_val     = len_ff + FRAME_LEN_W'(1);

   assign fr_wr_en   = accept & (req_item.action == ACT_BYTE) & room;
   assign fr_wr_addr = len_ff[FW-1:0];
   assign fr_wr_data = req_item.data_byte;

   always_comb begin
      frame_ok = room & ~ovf_ff & (len_ff >= FRAME_LEN_W'(MIN_FRAME - 1))
               & (crc_p1_ff == {last_ff, req_item.data_byte})
               & (hdr_ff[0] == dev_addr) & (dev_addr != 8'd0);
      q_data         = '0;
      q_data.is_load = (req_item.action == ACT_LOAD);
      q_data.bits    = req_item.input_bits;
      q_data.n       = n_val;
      q_data.fc      = hdr_ff[1];
      q_data.addr    = {hdr_ff[2], hdr_ff[3]};
      q_data.len     = {hdr_ff[4], hdr_ff[5]};
      q_push = accept & ((req_item.action == ACT_LOAD) | (req_item.frame_end & frame_ok));

      len_in     = len_ff;
      ovf_in     = ovf_ff;
      crc_cur_in = crc_cur_ff;
      crc_p1_in  = crc_p1_ff;
      last_in    = last_ff;
      pend_in    = pend_ff & ~status.frame_done;
      if (accept && req_item.action == ACT_BYTE) begin
         if (room) begin
            len_in     = n_val;
            crc_p1_in  = crc_cur_ff;
            crc_cur_in = crc_next(crc_cur_ff, req_item.data_byte);
            last_in    = req_item.data_byte;
         end else begin
            ovf_in = 1'b1;
         end
         if (req_item.frame_end) begin
            len_in     = '0;
            ovf_in     = 1'b0;
            crc_cur_in = CRC_INIT;
            crc_p1_in  = CRC_INIT;
            if (frame_ok) begin
               pend_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= '0;
         ovf_ff     <= 1'b0;
         crc_cur_ff <= CRC_INIT;
         crc_p1_ff  <= CRC_INIT;
         pend_ff    <= 1'b0;
      end else begin
         len_ff     <= len_in;
         ovf_ff     <= ovf_in;
         crc_cur_ff <= crc_cur_in;
         crc_p1_ff  <= crc_p1_in;
         pend_ff    <= pend_in;
      end
      last_ff <= last_in;
      if (fr_wr_en && len_ff < FRAME_LEN_W'(HDR_BYTES)) begin
         hdr_ff[len_ff[2:0]] <= req_item.data_byte;
      end
   end

endmodule

### rtl/mrs_fifo.sv
// short job queue between front and back ends
// depends on mrs_pkg
module mrs_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mrs_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output mrs_pkg::job_type pop_data
);
   import mrs_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   job_type         slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0]   cnt_ff, cnt_in;

   assign full     = cnt_ff == CW'(QUEUE_DEPTH);
   assign empty    = cnt_ff == '0;
   assign pop_data = slot_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = (wp_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_ff + PW'(1);
      end
      if (pop) begin
         rp_in = (rp_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_ff + PW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wp_ff] <= push_data;
      end
   end

endmodule

### rtl/mrs_back.sv
// back end: clears the banks, takes input loads, checks jobs, runs bank reads and writes, streams the response with crc
// depends on mrs_pkg and mrs_ram
module mrs_back #(
   parameter int BANK_DEPTH  = mrs_pkg::BANK_DEPTH_DEF,
   parameter int FRAME_BYTES = mrs_pkg::FRAME_BYTES_DEF,
   parameter int MAX_READ    = mrs_pkg::MAX_READ_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [7:0]                     dev_addr,
   input  logic                           q_empty,
   input  mrs_pkg::job_type               q_data,
   output logic                           q_pop,
   output mrs_pkg::back_status_type       status,
   output logic                           fr_rd_en,
   output logic [$clog2(FRAME_BYTES)-1:0] fr_rd_addr,
   input  logic [7:0]                     fr_rd_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output mrs_pkg::rsp_item_type          rsp_item
);
   import mrs_pkg::*;

   localparam int AW = $clog2(BANK_DEPTH);
   localparam int CW = $clog2(BANK_DEPTH + 1);
   localparam int FW = $clog2(FRAME_BYTES);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_CHECK, ST_SINGLE, ST_MW_HI, ST_MW_LO, ST_MW_WR,
      ST_HDR, ST_RD_ISSUE, ST_RD_HI, ST_RD_LO, ST_CRC_HI, ST_CRC_LO
   } state_type;

   state_type     state_ff, state_in;
   job_type       job_ff, job_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [FW-1:0] fidx_ff, fidx_in;
   logic [7:0]    hi_ff, hi_in;
   logic [2:0]    hidx_ff, hidx_in;
   logic [15:0]   crc_ff, crc_in;
   logic [7:0]    disc_ff, disc_in;
   logic [7:0]    cimg_ff, cimg_in;
   logic [2:0]    baud_ff, baud_in;
   logic [15:0]   gap_ff, gap_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_item_ff, rsp_item_in;

   logic          coil_we, hold_we, coil_re, hold_re;
   logic [AW-1:0] bank_wa;
   logic [15:0]   bank_wd, coil_q, hold_q;

   logic          out_free, push, push_last;
   logic [7:0]    push_byte, hdr_byte;
   logic          is_read, is_single, is_multi, valid_job;
   logic [16:0]   end_sum;
   logic [17:0]   need_n;
   logic [15:0]   word;
   logic [AW-1:0] ptr_m1;
   logic          disc_hit;

   mrs_ram #(.WIDTH(16), .DEPTH(BANK_DEPTH)) u_coil (
      .clock(clock), .wr_en(coil_we), .wr_addr(bank_wa), .wr_data(bank_wd),
      .rd_en(coil_re), .rd_addr(ptr_ff), .rd_data(coil_q)
   );

   mrs_ram #(.WIDTH(16), .DEPTH(BANK_DEPTH)) u_hold (
      .clock(clock), .wr_en(hold_we), .wr_addr(bank_wa), .wr_data(bank_wd),
      .rd_en(hold_re), .rd_addr(ptr_ff), .rd_data(hold_q)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_item   = rsp_item_ff;
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign fr_rd_addr = fidx_ff;

   always_comb begin
      is_read = (job_ff.fc == FC_READ_COILS) || (job_ff.fc == FC_READ_DISCRETE)
             || (job_ff.fc == FC_READ_HOLDING) || (job_ff.fc == FC_READ_INPUT);
      is_single = (job_ff.fc == FC_WRITE_COIL) || (job_ff.fc == FC_WRITE_REG);
      is_multi  = (job_ff.fc == FC_WRITE_COILS) || (job_ff.fc == FC_WRITE_REGS);
      end_sum   = {1'b0, job_ff.addr} + {1'b0, job_ff.len};
      need_n    = 18'(9) + {1'b0, job_ff.len, 1'b0};
      valid_job = 1'b0;
      if (is_read) begin
         valid_job = (job_ff.len != 16'd0) && (job_ff.len <= 16'(MAX_READ))
                  && (end_sum <= 17'(BANK_DEPTH));
      end else if (is_single) begin
         valid_job = job_ff.addr < 16'(BANK_DEPTH);
      end else if (is_multi) begin
         valid_job = (job_ff.len != 16'd0) && (end_sum <= 17'(BANK_DEPTH))
                  && ({9'd0, job_ff.n} >= need_n);
      end

      case (hidx_ff)
         3'd0:    hdr_byte = dev_addr;
         3'd1:    hdr_byte = job_ff.fc;
         3'd2:    hdr_byte = is_read ? {job_ff.len[6:0], 1'b0} : job_ff.addr[15:8];
         3'd3:    hdr_byte = job_ff.addr[7:0];
         3'd4:    hdr_byte = job_ff.len[15:8];
         3'd5:    hdr_byte = job_ff.len[7:0];
         default: hdr_byte = 8'd0;
      endcase

      ptr_m1   = ptr_ff - AW'(1);
      disc_hit = (ptr_ff != '0) && (ptr_ff <= AW'(8)) && disc_ff[ptr_m1[2:0]];
      case (job_ff.fc)
         FC_READ_COILS:    word = coil_q;
         FC_READ_HOLDING:  word = hold_q;
         FC_READ_DISCRETE: word = disc_hit ? DISC_ON : DISC_OFF;
         default:          word = 16'd0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      ptr_in   = ptr_ff;
      cnt_in   = cnt_ff;
      fidx_in  = fidx_ff;
      hi_in    = hi_ff;
      hidx_in  = hidx_ff;
      crc_in   = crc_ff;
      disc_in  = disc_ff;
      cimg_in  = cimg_ff;
      baud_in  = baud_ff;
      gap_in   = gap_ff;
      q_pop    = 1'b0;
      status   = '0;
      fr_rd_en = 1'b0;
      coil_we  = 1'b0;
      hold_we  = 1'b0;
      coil_re  = 1'b0;
      hold_re  = 1'b0;
      bank_wa  = ptr_ff;
      bank_wd  = 16'd0;
      push      = 1'b0;
      push_last = 1'b0;
      push_byte = 8'd0;

      case (state_ff)
         ST_CLEAR: begin
            status.clearing = 1'b1;
            coil_we = 1'b1;
            hold_we = 1'b1;
            ptr_in  = ptr_ff + AW'(1);
            if (ptr_ff == AW'(BANK_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               job_in = q_data;
               if (q_data.is_load) begin
                  disc_in = q_data.bits;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            crc_in  = CRC_INIT;
            hidx_in = '0;
            ptr_in  = job_ff.addr[AW-1:0];
            cnt_in  = job_ff.len[CW-1:0];
            fidx_in = FW'(MW_DATA_START);
            if (!valid_job) begin
               status.frame_done = 1'b1;
               state_in = ST_IDLE;
            end else if (is_single) begin
               state_in = ST_SINGLE;
            end else if (is_multi) begin
               state_in = ST_MW_HI;
            end else begin
               state_in = ST_HDR;
            end
         end
         ST_SINGLE, ST_MW_WR: begin
            bank_wd = (state_ff == ST_SINGLE) ? job_ff.len : {hi_ff, fr_rd_data};
            if (job_ff.fc == FC_WRITE_COIL || job_ff.fc == FC_WRITE_COILS) begin
               coil_we = 1'b1;
               if (ptr_ff != '0 && ptr_ff <= AW'(8)) begin
                  cimg_in[ptr_m1[2:0]] = bank_wd != 16'd0;
               end
            end else begin
               hold_we = 1'b1;
               if (ptr_ff == AW'(REG_BAUD) && bank_wd >= BAUD_MIN && bank_wd <= BAUD_MAX) begin
                  baud_in = bank_wd[2:0];
               end
               if (ptr_ff == AW'(REG_GAP)) begin
                  gap_in = bank_wd;
               end
            end
            if (state_ff == ST_SINGLE) begin
               state_in = ST_HDR;
            end else begin
               ptr_in = ptr_ff + AW'(1);
               cnt_in = cnt_ff - CW'(1);
               state_in = (cnt_ff == CW'(1)) ? ST_HDR : ST_MW_HI;
            end
         end
         ST_MW_HI: begin
            fr_rd_en = 1'b1;
            fidx_in  = fidx_ff + FW'(1);
            state_in = ST_MW_LO;
         end
         ST_MW_LO: begin
            hi_in    = fr_rd_data;
            fr_rd_en = 1'b1;
            fidx_in  = fidx_ff + FW'(1);
            state_in = ST_MW_WR;
         end
         ST_HDR: begin
            if (out_free) begin
               push      = 1'b1;
               push_byte = hdr_byte;
               crc_in    = crc_next(crc_ff, hdr_byte);
               hidx_in   = hidx_ff + 3'd1;
               if (is_read && hidx_ff == 3'd2) begin
                  state_in = ST_RD_ISSUE;
               end else if (!is_read && hidx_ff == 3'(HDR_BYTES - 1)) begin
                  state_in = ST_CRC_HI;
               end
            end
         end
         ST_RD_ISSUE: begin
            coil_re  = job_ff.fc == FC_READ_COILS;
            hold_re  = job_ff.fc == FC_READ_HOLDING;
            state_in = ST_RD_HI;
         end
         ST_RD_HI: begin
            if (out_free) begin
               push      = 1'b1;
               push_byte = word[15:8];
               crc_in    = crc_next(crc_ff, word[15:8]);
               state_in  = ST_RD_LO;
            end
         end
         ST_RD_LO: begin
            if (out_free) begin
               push      = 1'b1;
               push_byte = word[7:0];
               crc_in    = crc_next(crc_ff, word[7:0]);
               ptr_in    = ptr_ff + AW'(1);
               cnt_in    = cnt_ff - CW'(1);
               state_in  = (cnt_ff == CW'(1)) ? ST_CRC_HI : ST_RD_ISSUE;
            end
         end
         ST_CRC_HI: begin
            if (out_free) begin
               push      = 1'b1;
               push_byte = crc_ff[15:8];
               state_in  = ST_CRC_LO;
            end
         end
         ST_CRC_LO: begin
            if (out_free) begin
               push      = 1'b1;
               push_last = 1'b1;
               push_byte = crc_ff[7:0];
               status.frame_done = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_item_in  = rsp_item_ff;
      if (push) begin
         rsp_valid_in             = 1'b1;
         rsp_item_in.tx_byte      = push_byte;
         rsp_item_in.last_byte    = push_last;
         rsp_item_in.coil_image   = cimg_ff;
         rsp_item_in.baud_select  = baud_ff;
         rsp_item_in.gap_interval = gap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         disc_ff      <= '0;
         cimg_ff      <= '0;
         baud_ff      <= '0;
         gap_ff       <= GAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         disc_ff      <= disc_in;
         cimg_ff      <= cimg_in;
         baud_ff      <= baud_in;
         gap_ff       <= gap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff      <= job_in;
      cnt_ff      <= cnt_in;
      fidx_ff     <= fidx_in;
      hi_ff       <= hi_in;
      hidx_ff     <= hidx_in;
      crc_ff      <= crc_in;
      rsp_item_ff <= rsp_item_in;
   end

endmodule

### rtl/modbus_rtu_slave_engine.sv
// top level of the modbus rtu slave engine: front end, job queue, back end, frame ram
// depends on mrs_pkg, mrs_ram, mrs_front, mrs_fifo, mrs_back
//
//   port group   direction   handshake        payload
//   req_         in          valid / stall    req_item_type
//   rsp_         out         valid / stall    rsp_item_type
//   csr_         in          valid / ready    device address, 8 bits
//
// a frame byte or input load enters when req_valid is high and req_stall is low; a frame end
// then runs a single write, a multiple write or a read in the back end, which holds while a
// response byte is stalled; a rejected frame gets no response
// after reset the back end clears both banks with req_stall high
// req_stall also holds while a frame is in work or the job queue is full
module modbus_rtu_slave_engine #(
   parameter int BANK_DEPTH  = mrs_pkg::BANK_DEPTH_DEF,
   parameter int FRAME_BYTES = mrs_pkg::FRAME_BYTES_DEF,
   parameter int MAX_READ    = mrs_pkg::MAX_READ_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mrs_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mrs_pkg::rsp_item_type rsp_item,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [7:0]            csr_data
);
   import mrs_pkg::*;

   localparam int FW = $clog2(FRAME_BYTES);

   logic [7:0]      dev_ff;
   back_status_type status;
   logic            q_push, q_full, q_pop, q_empty;
   job_type         q_in, q_out;
   logic            fr_wr_en, fr_rd_en;
   logic [FW-1:0]   fr_wr_addr, fr_rd_addr;
   logic [7:0]      fr_wr_data, fr_rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_ff <= ADDR_RESET;
      end else if (csr_valid && csr_ready) begin
         dev_ff <= csr_data;
      end
   end

   mrs_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_item(req_item), .dev_addr(dev_ff), .status(status), .q_full(q_full),
      .q_push(q_push), .q_data(q_in), .fr_wr_en(fr_wr_en), .fr_wr_addr(fr_wr_addr),
      .fr_wr_data(fr_wr_data)
   );

   mrs_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame (
      .clock(clock), .wr_en(fr_wr_en), .wr_addr(fr_wr_addr), .wr_data(fr_wr_data),
      .rd_en(fr_rd_en), .rd_addr(fr_rd_addr), .rd_data(fr_rd_data)
   );

   mrs_fifo u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_data(q_in), .full(q_full),
      .pop(q_pop), .empty(q_empty), .pop_data(q_out)
   );

   mrs_back #(
      .BANK_DEPTH(BANK_DEPTH), .FRAME_BYTES(FRAME_BYTES), .MAX_READ(MAX_READ)
   ) u_back (
      .clock(clock), .reset(reset), .dev_addr(dev_ff), .q_empty(q_empty),
      .q_data(q_out), .q_pop(q_pop), .status(status), .fr_rd_en(fr_rd_en),
      .fr_rd_addr(fr_rd_addr), .fr_rd_data(fr_rd_data), .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall), .rsp_item(rsp_item)
   );

endmodule

### rtl/mrs_checker.sv
// port-level checks for the modbus rtu slave engine, bound to the top level
// depends on mrs_pkg and modbus_rtu_slave_engine_assert.svh
`include "modbus_rtu_slave_engine_assert.svh"

module mrs_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input mrs_pkg::req_item_type req_item,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input mrs_pkg::rsp_item_type rsp_item,
   input logic                  csr_valid,
   input logic                  csr_ready,
   input logic [7:0]            csr_data
);
   import mrs_pkg::*;

   // a stalled result holds
   `MRS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item))

   // nothing is offered right after reset
   `MRS_ASSERT_IMPLY(a_rsp_after_reset, clock, reset, $past(reset), !rsp_valid)

   // status fields stay fixed within one response
   `MRS_ASSERT_NEXT(a_status_steady, clock, reset, rsp_valid && !rsp_stall && !rsp_item.last_byte, $stable(rsp_item.coil_image) && $stable(rsp_item.baud_select) && $stable(rsp_item.gap_interval))

endmodule

bind modbus_rtu_slave_engine mrs_checker u_checker (.*);
